FILE: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int unsigned TICK_W    = 16;
	localparam int unsigned STEP_W    = 2;
	localparam int unsigned BITCNT_W  = 4;
	localparam int unsigned ADDR_W    = 3;
	localparam int unsigned PDATA_W   = 32;

	// command codes on the func field; anything else is no command
	localparam logic [2:0] FUNC_NONE  = 3'd0;
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_STOP  = 3'd2;
	localparam logic [2:0] FUNC_WRITE = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;

	// register index (word address bit)
	localparam logic REG_PHASE_TICKS = 1'b0;

	localparam logic [TICK_W-1:0]   PHASE_TICKS_RST = 16'd4;
	localparam logic [7:0]          MSB_MASK        = 8'h80;
	localparam logic [BITCNT_W-1:0] ACK_SLOT        = 4'd8;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_data;
		logic       ack_seen;
		logic       rejected;
	} res_t;

endpackage

FILE: design/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer state and one-tick next-state logic.
// ----------------------------------------------------------------------------
module i2cm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           phase_ticks,
	input  logic                  step_en,
	input  i2cm_pkg::cmd_t        item,
	output i2cm_pkg::res_t        res
);
	import i2cm_pkg::*;

	typedef enum logic [4:0] {
		OP_IDLE  = 5'b00001,
		OP_START = 5'b00010,
		OP_STOP  = 5'b00100,
		OP_WRITE = 5'b01000,
		OP_READ  = 5'b10000
	} op_t;

	typedef struct packed {
		logic scl;
		logic sda;
	} lines_t;

	op_t                 op_q;
	logic [STEP_W-1:0]   step_q;
	logic [BITCNT_W-1:0] bit_q;
	logic [TICK_W-1:0]   tick_q;
	logic [7:0]          shift_q;
	logic                ackc_q;
	lines_t              lines_q;
	logic [7:0]          rx_hold_q;
	logic                ack_hold_q;

	op_t                 op_n;
	logic [STEP_W-1:0]   step_n;
	logic [BITCNT_W-1:0] bit_n;
	logic [TICK_W-1:0]   tick_n;
	logic [7:0]          shift_n;
	logic                ackc_n;
	lines_t              lines_n;
	logic [7:0]          rx_hold_n;
	logic                ack_hold_n;
	logic                done;
	logic                rej;
	logic                is_cmd;
	logic [TICK_W-1:0]   limit;

	// line levels of a freshly entered phase
	function automatic lines_t enter_lines(op_t op, logic [STEP_W-1:0] step,
			logic [BITCNT_W-1:0] bitc, logic [7:0] shift, logic ackc, lines_t cur);
		lines_t l;
		l = cur;
		case (op)
			OP_START: begin
				case (step)
					2'd0:    l.sda = 1'b0;
					2'd1:    l.scl = 1'b1;
					2'd2:    l.sda = 1'b1;
					default: l.scl = 1'b0;
				endcase
			end
			OP_STOP: begin
				case (step)
					2'd0: begin
						l.scl = 1'b0;
						l.sda = 1'b1;
					end
					2'd1:    l.scl = 1'b1;
					default: l.sda = 1'b0;
				endcase
			end
			OP_WRITE, OP_READ: begin
				if (step == 2'd0) begin
					l.scl = 1'b0;
					if (bitc >= ACK_SLOT)
						l.sda = (op == OP_READ) ? ackc : 1'b0;
					else if (op == OP_WRITE)
						l.sda = ((shift & MSB_MASK) != 8'd0) ? 1'b0 : 1'b1;
					else
						l.sda = 1'b0;
				end else begin
					l.scl = 1'b1;
				end
			end
			default: ;
		endcase
		return l;
	endfunction

	always_comb begin
		op_n       = op_q;
		step_n     = step_q;
		bit_n      = bit_q;
		tick_n     = tick_q;
		shift_n    = shift_q;
		ackc_n     = ackc_q;
		lines_n    = lines_q;
		rx_hold_n  = rx_hold_q;
		ack_hold_n = ack_hold_q;
		done       = 1'b0;
		rej        = 1'b0;
		is_cmd     = (item.func == FUNC_START) || (item.func == FUNC_STOP) ||
		             (item.func == FUNC_WRITE) || (item.func == FUNC_READ);
		limit      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

		if (op_q != OP_IDLE) begin
			rej = is_cmd;
			if (tick_q >= limit) begin
				if (op_q == OP_START || op_q == OP_STOP) begin
					if (step_q >= ((op_q == OP_START) ? 2'd3 : 2'd2)) begin
						done = 1'b1;
					end else begin
						step_n  = step_q + 2'd1;
						lines_n = enter_lines(op_q, step_n, bit_q, shift_q, ackc_q, lines_q);
						tick_n  = 16'd1;
					end
				end else if (step_q == 2'd0) begin
					step_n  = 2'd1;
					lines_n = enter_lines(op_q, step_n, bit_q, shift_q, ackc_q, lines_q);
					tick_n  = 16'd1;
				end else if (bit_q >= ACK_SLOT) begin
					if (op_q == OP_WRITE) ack_hold_n = item.sda_in;
					else                  rx_hold_n  = shift_q;
					lines_n.scl = 1'b0;
					done        = 1'b1;
				end else begin
					shift_n = (op_q == OP_WRITE) ? {shift_q[6:0], 1'b0}
					                             : {shift_q[6:0], item.sda_in};
					bit_n   = bit_q + 4'd1;
					step_n  = 2'd0;
					lines_n = enter_lines(op_q, step_n, bit_n, shift_n, ackc_q, lines_q);
					tick_n  = 16'd1;
				end
				if (done) begin
					op_n   = OP_IDLE;
					step_n = 2'd0;
					bit_n  = 4'd0;
					tick_n = 16'd0;
				end
			end else begin
				tick_n = tick_q + 16'd1;
			end
		end else if (is_cmd) begin
			case (item.func)
				FUNC_START: op_n = OP_START;
				FUNC_STOP:  op_n = OP_STOP;
				FUNC_WRITE: op_n = OP_WRITE;
				default:    op_n = OP_READ;
			endcase
			step_n  = 2'd0;
			bit_n   = 4'd0;
			shift_n = (item.func == FUNC_WRITE) ? item.tx_byte : 8'd0;
			ackc_n  = item.send_ack;
			lines_n = enter_lines(op_n, step_n, bit_n, shift_n, ackc_n, lines_q);
			tick_n  = 16'd1;
		end

		res.scl_level    = lines_n.scl;
		res.sda_pull_low = lines_n.sda;
		res.busy_res     = (op_n != OP_IDLE);
		res.done_res     = done;
		res.rx_data      = rx_hold_n;
		res.ack_seen     = ack_hold_n;
		res.rejected     = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= OP_IDLE;
			step_q     <= '0;
			bit_q      <= '0;
			tick_q     <= '0;
			shift_q    <= '0;
			ackc_q     <= 1'b0;
			lines_q    <= '{scl: 1'b1, sda: 1'b0};
			rx_hold_q  <= '0;
			ack_hold_q <= 1'b1;
		end else if (step_en) begin
			op_q       <= op_n;
			step_q     <= step_n;
			bit_q      <= bit_n;
			tick_q     <= tick_n;
			shift_q    <= shift_n;
			ackc_q     <= ackc_n;
			lines_q    <= lines_n;
			rx_hold_q  <= rx_hold_n;
			ack_hold_q <= ack_hold_n;
		end
	end

endmodule

FILE: design/i2cm_obuf.sv
// ----------------------------------------------------------------------------
// i2cm_obuf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module i2cm_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cm_pkg::res_t  din,
	output logic            full,
	output logic            res_valid,
	input  logic            res_ready,
	output i2cm_pkg::res_t  res
);
	import i2cm_pkg::*;

	res_t       head_q;
	res_t       tail_q;
	logic [1:0] count_q;
	logic       pop;

	assign res_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign res       = head_q;
	assign pop       = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) head_q <= din;
				else                 tail_q <= din;
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (count_q == 2'd2) begin
					head_q <= tail_q;
					tail_q <= din;
				end else begin
					head_q <= din;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: design/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C bus master: one command beat per tick in, one result beat per tick out.
// ----------------------------------------------------------------------------
// A command beat is registered in s1; its result beat is then registered in the result buffer.
// Throughput: one beat per cycle while the result buffer has room; the sequencer updates once per beat.
// A two-entry result buffer lets the input side keep going while a result waits.
// Reset (arst_n low, async): bus idle, SCL released, SDA released, phase_ticks 4,
// rx_data 0, ack_seen 1, no beats pending.
module i2c_master_byte_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  i2cm_pkg::cmd_t                  cmd,
	// result channel
	output logic                            res_valid,
	input  logic                            res_ready,
	output i2cm_pkg::res_t                  res,
	// APB-style register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [i2cm_pkg::ADDR_W-1:0]     paddr,
	input  logic [i2cm_pkg::PDATA_W-1:0]    pwdata,
	output logic [i2cm_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import i2cm_pkg::*;

	logic [TICK_W-1:0] phase_ticks_q;
	logic              reg_wr;

	cmd_t              cmd_s1;
	logic              valid_s1;
	logic              adv;
	logic              buf_full;
	res_t              step_res;

	// ---------------- register port ----------------
	// single register at word 0; other words read as zero and ignore writes
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready &&
	                (paddr[ADDR_W-1] == REG_PHASE_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (reg_wr) begin
			phase_ticks_q <= pwdata[TICK_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1] == REG_PHASE_TICKS)
			prdata = {{(PDATA_W-TICK_W){1'b0}}, phase_ticks_q};
	end

	// ---------------- input stage ----------------
	// the s1 beat advances into the sequencer whenever the result buffer has room;
	// cmd_ready never looks at res_ready, so both sides are cut by registers
	assign adv       = valid_s1 && !buf_full;
	assign cmd_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready)
			cmd_s1 <= cmd;
	end

	// ---------------- sequencer ----------------
	// start/stop/byte sequencing; state steps once per advanced beat
	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_ticks (phase_ticks_q),
		.step_en     (adv),
		.item        (cmd_s1),
		.res         (step_res)
	);

	// ---------------- result buffer ----------------
	i2cm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.din       (step_res),
		.full      (buf_full),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// ---------------- checks ----------------
	// a finishing tick always leaves the bus idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.done_res) |-> !res.busy_res)
		else $error("done beat reports busy");

	// a stalled input stage only happens with a beat held in s1
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> (valid_s1 && buf_full))
		else $error("input stalled without a held beat");

	// no beat reaches the sequencer while the result buffer is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |=> (res_valid && (buf_full || !$past(adv) || $past(res_ready))))
		else $error("result buffer overflow");

	// a register write lands in phase_ticks
	a_reg_write: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wr |=> (phase_ticks_q == $past(pwdata[TICK_W-1:0])))
		else $error("phase_ticks write lost");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives i2c_master_byte_engine one tick beat at a time and checks every
// result beat against a tick-by-tick bus sequencer predictor kept in the bench.
// A short directed table covers reset levels, unknown funcs, busy rejects,
// the zero divider and every command; a stop at the widest divider holds its
// first phase for a while; random phases then mix well-formed commands
// with noise at several divider settings, under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import i2cm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RAND_PHASE_BEATS = 400;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned LONG_DIV_BEATS = 40;
	localparam int unsigned MAX_PRINTS = 50;
	// func values outside the command set, taken as no command
	localparam logic [2:0] FUNC_JUNK_LO = 3'd5;
	localparam logic [2:0] FUNC_JUNK_HI = 3'd7;
	localparam logic [ADDR_W-1:0] PT_ADDR = {REG_PHASE_TICKS, 2'b00};

	// levels that can be read straight off the sequences
	localparam res_t IDLE_LEVELS = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b0,
		done_res: 1'b0, rx_data: 8'h00, ack_seen: 1'b1, rejected: 1'b0};
	localparam res_t START_LEVELS = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b1,
		done_res: 1'b0, rx_data: 8'h00, ack_seen: 1'b1, rejected: 1'b0};
	localparam res_t BUSY_REJECT = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b1,
		done_res: 1'b0, rx_data: 8'h00, ack_seen: 1'b1, rejected: 1'b1};

	typedef struct {
		bit          set_pt;
		logic [15:0] pt;
		cmd_t        c;
		int          reps;
		bit          typed;
		res_t        want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	cmd_t                cmd = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	res_t                res;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = PT_ADDR;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// predictor state, mirrors the sequencer after each accepted beat
	logic [15:0] cfg_ticks = PHASE_TICKS_RST;
	logic [2:0]  p_op = FUNC_NONE;
	logic [2:0]  p_step = 3'd0;
	logic [3:0]  p_bits = 4'd0;
	logic [15:0] p_ticks = 16'd0;
	logic [7:0]  p_shift = 8'h00;
	logic        p_ackch = 1'b0;
	logic        p_scl = 1'b1;
	logic        p_sda = 1'b0;
	logic [7:0]  p_rx = 8'h00;
	logic        p_ack = 1'b1;

	res_t        pending_levels[$];
	row_t        rows[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned hold_cycles = 0;
	bit          quiet = 1'b0;

	i2c_master_byte_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats pending", cycles,
				pending_levels.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---- predictor ---------------------------------------------------------

	// line levels for the phase just entered
	function automatic void phase_enter();
		case (p_op)
			FUNC_START: begin
				case (p_step)
					3'd0: p_sda = 1'b0;
					3'd1: p_scl = 1'b1;
					3'd2: p_sda = 1'b1;
					default: p_scl = 1'b0;
				endcase
			end
			FUNC_STOP: begin
				if (p_step == 3'd0) begin
					p_scl = 1'b0;
					p_sda = 1'b1;
				end else if (p_step == 3'd1) begin
					p_scl = 1'b1;
				end else begin
					p_sda = 1'b0;
				end
			end
			FUNC_WRITE, FUNC_READ: begin
				if (p_step == 3'd0) begin
					p_scl = 1'b0;
					if (p_bits >= ACK_SLOT)
						p_sda = (p_op == FUNC_READ) ? p_ackch : 1'b0;
					else if (p_op == FUNC_WRITE)
						p_sda = ((p_shift & MSB_MASK) != 8'h00) ? 1'b0 : 1'b1;
					else
						p_sda = 1'b0;
				end else begin
					p_scl = 1'b1;
				end
			end
			default: ;
		endcase
		p_ticks = 16'd1;
	endfunction

	function automatic void seq_finish();
		p_op = FUNC_NONE;
		p_step = 3'd0;
		p_bits = 4'd0;
		p_ticks = 16'd0;
	endfunction

	// closes the current phase; 1 when the command is over
	function automatic bit phase_close(input logic sda_s);
		logic [2:0] last;
		if (p_op == FUNC_START || p_op == FUNC_STOP) begin
			last = (p_op == FUNC_START) ? 3'd3 : 3'd2;
			if (p_step >= last) begin
				seq_finish();
				return 1'b1;
			end
			p_step = p_step + 3'd1;
			phase_enter();
			return 1'b0;
		end
		if (p_step == 3'd0) begin
			p_step = 3'd1;
			phase_enter();
			return 1'b0;
		end
		// end of the ack slot: SCL drops in the same tick
		if (p_bits >= ACK_SLOT) begin
			if (p_op == FUNC_WRITE)
				p_ack = sda_s;
			else
				p_rx = p_shift;
			p_scl = 1'b0;
			seq_finish();
			return 1'b1;
		end
		if (p_op == FUNC_WRITE)
			p_shift = {p_shift[6:0], 1'b0};
		else
			p_shift = {p_shift[6:0], sda_s};
		p_bits = p_bits + 4'd1;
		p_step = 3'd0;
		phase_enter();
		return 1'b0;
	endfunction

	// advances the predictor by one tick beat, returns the bus levels after it
	function automatic res_t bus_tick(input cmd_t c);
		res_t        r;
		bit          is_cmd;
		bit          done;
		bit          rej;
		int unsigned lim;
		is_cmd = (c.func >= FUNC_START) && (c.func <= FUNC_READ);
		done = 1'b0;
		rej = 1'b0;
		lim = (cfg_ticks != 16'd0) ? cfg_ticks : 1;
		if (p_op != FUNC_NONE) begin
			if (is_cmd)
				rej = 1'b1;
			if (p_ticks >= lim)
				done = phase_close(c.sda_in);
			else
				p_ticks = p_ticks + 16'd1;
		end else if (is_cmd) begin
			p_op = c.func;
			p_step = 3'd0;
			p_bits = 4'd0;
			p_shift = (c.func == FUNC_WRITE) ? c.tx_byte : 8'h00;
			p_ackch = c.send_ack;
			phase_enter();
		end
		r.scl_level = p_scl;
		r.sda_pull_low = p_sda;
		r.busy_res = (p_op != FUNC_NONE);
		r.done_res = done;
		r.rx_data = p_rx;
		r.ack_seen = p_ack;
		r.rejected = rej;
		return r;
	endfunction

	// ---- stimulus helpers --------------------------------------------------

	function automatic int unsigned pick_gap();
		if (quiet || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// random tick beat; mostly well-formed commands when the engine is free
	function automatic cmd_t draw_cmd();
		cmd_t        c;
		int unsigned roll;
		c.tx_byte = 8'($urandom_range(0, 255));
		c.send_ack = 1'($urandom_range(0, 1));
		c.sda_in = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (p_op == FUNC_NONE) begin
			if (roll < 10)
				c.func = FUNC_NONE;
			else if (roll < 14)
				c.func = 3'($urandom_range(FUNC_JUNK_LO, FUNC_JUNK_HI));
			else if (roll < 20)
				c.func = FUNC_START;
			else if (roll < 26)
				c.func = FUNC_STOP;
			else if (roll < 63)
				c.func = FUNC_WRITE;
			else
				c.func = FUNC_READ;
		end else begin
			if (roll < 85)
				c.func = FUNC_NONE;
			else if (roll < 90)
				c.func = 3'($urandom_range(FUNC_JUNK_LO, FUNC_JUNK_HI));
			else
				c.func = 3'($urandom_range(FUNC_START, FUNC_READ)); // dropped, busy
		end
		return c;
	endfunction

	function automatic void add_row(input bit set_pt, input logic [15:0] pt,
		input logic [2:0] f, input logic [7:0] tx, input logic ack, input logic sda,
		input int reps, input bit typed, input res_t want);
		row_t r;
		r.set_pt = set_pt;
		r.pt = pt;
		r.c = '{func: f, tx_byte: tx, send_ack: ack, sda_in: sda};
		r.reps = reps;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endfunction

	// one command beat; valid stays up into the next beat when no gap is drawn
	task automatic send_beat(input cmd_t c, input bit typed, input res_t want);
		int unsigned gap;
		res_t        lv;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		lv = bus_tick(c);
		pending_levels.push_back(typed ? want : lv);
	endtask

	// sender waits until every result beat is back, then a short pause
	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write phase_ticks, then read it back in a second transfer
	task automatic reg_write(input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_ticks = value[15:0];
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== cfg_ticks)
			report_mismatch($sformatf("phase_ticks read %h, wrote %h", prdata[15:0],
				cfg_ticks));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// ---- checking ----------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	task automatic check_levels(input res_t got);
		res_t want;
		if (pending_levels.size() == 0) begin
			report_mismatch("result beat with nothing pending");
			return;
		end
		want = pending_levels.pop_front();
		if (got.scl_level !== want.scl_level)
			report_mismatch($sformatf("scl_level %b want %b", got.scl_level,
				want.scl_level));
		if (got.sda_pull_low !== want.sda_pull_low)
			report_mismatch($sformatf("sda_pull_low %b want %b", got.sda_pull_low,
				want.sda_pull_low));
		if (got.busy_res !== want.busy_res)
			report_mismatch($sformatf("busy_res %b want %b", got.busy_res, want.busy_res));
		if (got.done_res !== want.done_res)
			report_mismatch($sformatf("done_res %b want %b", got.done_res, want.done_res));
		if (got.rx_data !== want.rx_data)
			report_mismatch($sformatf("rx_data %h want %h", got.rx_data, want.rx_data));
		if (got.ack_seen !== want.ack_seen)
			report_mismatch($sformatf("ack_seen %b want %b", got.ack_seen, want.ack_seen));
		if (got.rejected !== want.rejected)
			report_mismatch($sformatf("rejected %b want %b", got.rejected, want.rejected));
	endtask

	// result side: random stalls, plus a long hold-off when one is requested
	initial begin
		int unsigned gap;
		wait (arst_n);
		forever begin
			if (hold_cycles > 0) begin
				gap = hold_cycles;
				hold_cycles = 0;
			end else begin
				gap = pick_gap();
			end
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			check_levels(res);
		end
	end

	// ---- main sequence -----------------------------------------------------

	initial begin
		logic [15:0] rand_pt[5];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		// reset levels, unknown funcs, first start tick, reject while busy
		add_row(0, 16'd0, FUNC_NONE, 8'h00, 1'b0, 1'b0, 1, 1, IDLE_LEVELS);
		add_row(0, 16'd0, FUNC_JUNK_HI, 8'hFF, 1'b1, 1'b1, 1, 1, IDLE_LEVELS);
		add_row(0, 16'd0, FUNC_JUNK_LO, 8'hFF, 1'b1, 1'b0, 1, 1, IDLE_LEVELS);
		add_row(0, 16'd0, FUNC_START, 8'hFF, 1'b1, 1'b0, 1, 1, START_LEVELS);
		add_row(0, 16'd0, FUNC_WRITE, 8'hFF, 1'b1, 1'b0, 1, 1, BUSY_REJECT);
		add_row(0, 16'd0, FUNC_NONE, 8'h00, 1'b0, 1'b1, 20, 0, '0);
		// zero divider: write all ones, slave acks
		add_row(1, 16'd0, FUNC_WRITE, 8'hFF, 1'b0, 1'b0, 1, 0, '0);
		add_row(0, 16'd0, FUNC_NONE, 8'h00, 1'b0, 1'b0, 19, 0, '0);
		// read all ones with ack, then all zeros with nack
		add_row(0, 16'd0, FUNC_READ, 8'h00, 1'b1, 1'b1, 1, 0, '0);
		add_row(0, 16'd0, FUNC_NONE, 8'hFF, 1'b1, 1'b1, 19, 0, '0);
		add_row(0, 16'd0, FUNC_READ, 8'hFF, 1'b0, 1'b0, 1, 0, '0);
		add_row(0, 16'd0, FUNC_NONE, 8'h00, 1'b0, 1'b0, 19, 0, '0);
		// write all zeros, slave nacks
		add_row(0, 16'd0, FUNC_WRITE, 8'h00, 1'b1, 1'b1, 1, 0, '0);
		add_row(0, 16'd0, FUNC_NONE, 8'h00, 1'b1, 1'b1, 19, 0, '0);
		// command landing on the finishing tick of a start is dropped
		add_row(0, 16'd0, FUNC_START, 8'h00, 1'b0, 1'b0, 1, 0, '0);
		add_row(0, 16'd0, FUNC_NONE, 8'h00, 1'b0, 1'b0, 3, 0, '0);
		add_row(0, 16'd0, FUNC_READ, 8'h00, 1'b1, 1'b0, 1, 0, '0);
		add_row(0, 16'd0, FUNC_NONE, 8'h00, 1'b0, 1'b0, 1, 0, '0);
		// stop ignores tx_byte and send_ack
		add_row(0, 16'd0, FUNC_STOP, 8'hA5, 1'b1, 1'b0, 1, 0, '0);
		add_row(0, 16'd0, FUNC_NONE, 8'h00, 1'b0, 1'b0, 4, 0, '0);
		// divider of one, mixed byte
		add_row(1, 16'd1, FUNC_WRITE, 8'hA5, 1'b0, 1'b1, 1, 0, '0);
		add_row(0, 16'd0, FUNC_NONE, 8'h5A, 1'b1, 1'b0, 19, 0, '0);

		foreach (rows[i]) begin
			if (rows[i].set_pt) begin
				drain();
				reg_write({16'($urandom), rows[i].pt});
			end
			for (int n = 0; n < rows[i].reps; n++)
				send_beat(rows[i].c, rows[i].typed, rows[i].want);
		end

		// widest divider: a stop sits in its first phase for a while, no idling
		quiet = 1'b1;
		drain();
		reg_write({16'($urandom), 16'hFFFF});
		send_beat('{func: FUNC_STOP, tx_byte: 8'h00, send_ack: 1'b0, sda_in: 1'b1}, 0, '0);
		for (int n = 0; n < LONG_DIV_BEATS; n++)
			send_beat(draw_cmd(), 0, '0);
		quiet = 1'b0;

		// random phases at short dividers
		rand_pt[0] = 16'd1;
		rand_pt[1] = 16'd2;
		rand_pt[2] = 16'd0;
		rand_pt[3] = 16'd3;
		rand_pt[4] = 16'($urandom_range(1, 6));
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			reg_write({16'($urandom), rand_pt[ph]});
			if (ph == 1) begin
				// result side holds off while beats keep coming: buffer fills
				hold_cycles = LONG_HOLD;
				quiet = 1'b1;
			end
			for (int n = 0; n < RAND_PHASE_BEATS; n++) begin
				if (n == 150)
					quiet = 1'b0;
				send_beat(draw_cmd(), 0, '0);
			end
		end

		cmd_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
